FILE: rtl/ipv6_ext_header_chain_table_defines.svh
// ----------------------------------------------------------------------------
// IPv6 extension header chain table - assertion macros
// Shared concurrent assertion forms for the chain table blocks.
// ----------------------------------------------------------------------------
`ifndef IPV6_EXT_HEADER_CHAIN_TABLE_DEFINES_SVH
`define IPV6_EXT_HEADER_CHAIN_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IEHC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iehc: same-cycle check failed");

// next-cycle implication, disabled during reset
`define IEHC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iehc: next-cycle check failed");

`endif

FILE: rtl/iehc_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 extension header chain table - package
// Field widths, operation and status codes, header types, ordering helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iehc_pkg;

   // field widths
   localparam int FUNC_W   = 3;
   localparam int TYPE_W   = 8;
   localparam int LEN_W    = 12;
   localparam int OCC_W    = 3;
   localparam int CHUNK_W  = 17;
   localparam int STAT_W   = 3;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 4;
   localparam int TOTAL_W  = 15;
   localparam int ORD_W    = 4;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;

   // length constants
   localparam int HDR_BYTES  = 40;
   localparam int LEN_MAX    = 2048;
   localparam int LEN15_MAX  = 32767;

   // operation codes (5..7 act as a query)
   localparam logic [FUNC_W-1:0] FN_INSERT       = 3'd0;
   localparam logic [FUNC_W-1:0] FN_FIND         = 3'd1;
   localparam logic [FUNC_W-1:0] FN_REMOVE_FIRST = 3'd2;
   localparam logic [FUNC_W-1:0] FN_REMOVE_TYPE  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_QUERY        = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_DUP       = 3'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_LEN   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd5;

   // next-header protocol numbers
   localparam logic [TYPE_W-1:0] T_HOP      = 8'd0;
   localparam logic [TYPE_W-1:0] T_DEST     = 8'd60;
   localparam logic [TYPE_W-1:0] T_ROUTING  = 8'd43;
   localparam logic [TYPE_W-1:0] T_FRAGMENT = 8'd44;
   localparam logic [TYPE_W-1:0] T_AUTH     = 8'd51;
   localparam logic [TYPE_W-1:0] T_ESP      = 8'd50;
   localparam logic [TYPE_W-1:0] T_MOB      = 8'd135;

   // chain order ranks
   localparam logic [ORD_W-1:0] ORD_HOP     = 4'd0;
   localparam logic [ORD_W-1:0] ORD_DEST1   = 4'd1;
   localparam logic [ORD_W-1:0] ORD_ROUTING = 4'd2;
   localparam logic [ORD_W-1:0] ORD_FRAG    = 4'd3;
   localparam logic [ORD_W-1:0] ORD_AUTH    = 4'd4;
   localparam logic [ORD_W-1:0] ORD_ESP     = 4'd5;
   localparam logic [ORD_W-1:0] ORD_DEST2   = 4'd6;
   localparam logic [ORD_W-1:0] ORD_MOB     = 4'd7;
   localparam logic [ORD_W-1:0] ORD_UNKNOWN = 4'd8;

   // one stored chain entry
   typedef struct packed {
      logic [TYPE_W-1:0] etype;
      logic [LEN_W-1:0]  elen;
   } entry_type;

   // sequencer states
   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_SHIFT_UP,
      SEQ_SHIFT_DOWN,
      SEQ_PUT,
      SEQ_LEN_START,
      SEQ_LEN,
      SEQ_FRAG
   } seq_state_type;

   // base rank of a header type; destination options report its first rank
   function automatic logic [ORD_W-1:0] base_order(input logic [TYPE_W-1:0] t);
      logic [ORD_W-1:0] ord;
      case (t)
         T_HOP:      ord = ORD_HOP;
         T_DEST:     ord = ORD_DEST1;
         T_ROUTING:  ord = ORD_ROUTING;
         T_FRAGMENT: ord = ORD_FRAG;
         T_AUTH:     ord = ORD_AUTH;
         T_ESP:      ord = ORD_ESP;
         T_MOB:      ord = ORD_MOB;
         default:    ord = ORD_UNKNOWN;
      endcase
      return ord;
   endfunction

endpackage

FILE: rtl/ipv6_ext_header_chain_table.sv
// ----------------------------------------------------------------------------
// IPv6 extension header chain table
// Ordered store of extension headers with insert, find, remove and lengths.
//
// One request beat is taken at a time; req_tready stays low until the result
// has been built. A request is accepted, then scanned entry by entry with a
// step to close the scan; an insert or remove then moves entries one by one,
// an insert places its entry, and the read restarts after an insert or a
// remove that moved entries. A length pass then runs over each entry of the
// resulting chain plus a closing step, and a finish step loads the result.
// A remove on an empty chain skips the scan. The finish step repeats while
// the previous result still waits in the output register. This sequence
// comes from the entry store with one read port, read one entry per cycle,
// and the one shared adder that accumulates lengths. The result waits in an
// output register, so the next request can be taken while rsp_tvalid is
// still high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv6_ext_header_chain_table_defines.svh"

module ipv6_ext_header_chain_table
   import iehc_pkg::*;
#(
   parameter int MAX_HEADERS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // ext_type[7:0], ext_length[19:8], occurrence[22:20], chunk_length[39:23]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[2:0]
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // position[3:0], found_type[11:4], found_length[23:12], entry_count[27:24],
   // total_length[42:28], unfragmentable_length[57:43],
   // fragment_length[74:58], not_fragment[75], zero[79:76]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [STAT_W-1:0]     rsp_tuser
);

   localparam int CW    = $clog2(MAX_HEADERS + 1);
   localparam int AW    = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1;
   localparam int RUN_W = $clog2(HDR_BYTES + MAX_HEADERS * LEN_MAX + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HEADERS);

   seq_state_type state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [TYPE_W-1:0]  type_ff, type_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [TYPE_W-1:0]  ftype_ff, ftype_in;
   logic [LEN_W-1:0]   flen_ff, flen_in;
   logic [ORD_W-1:0]   mine_ff, mine_in;
   logic               seen_ff, seen_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [RUN_W-1:0]   unfrag_ff, unfrag_in;
   logic [RUN_W-1:0]   sub_ff, sub_in;
   logic               nofrag_ff, nofrag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]     rsp_user_ff, rsp_user_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_entry;
   entry_type     rd_entry;

   logic [CHUNK_W-1:0] alu_a, alu_b, alu_res;
   logic               alu_sub, alu_carry;

   logic [CW-1:0]      idx_up, idx_dn, cnt_dn;
   logic [ORD_W-1:0]   theirs_base, theirs;
   logic               mine_known, bad_len, type_hit;
   logic [TOTAL_W-1:0] total_sat, unfrag_sat;
   logic [CHUNK_W-1:0] frag_val;
   logic               req_accept;

   assign idx_up = idx_ff + CW'(1);
   assign idx_dn = idx_ff - CW'(1);
   assign cnt_dn = count_ff - CW'(1);

   // entry storage
   iehc_store #(
      .DEPTH (MAX_HEADERS),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (idx_in[AW-1:0]),
      .rd_entry (rd_entry)
   );

   // shared adder: length sums during the length pass, fragment length at the end
   iehc_alu u_alu (
      .op_a      (alu_a),
      .op_b      (alu_b),
      .op_sub    (alu_sub),
      .result    (alu_res),
      .carry_out (alu_carry)
   );

   always_comb begin
      alu_sub = (state_ff == SEQ_FRAG);
      if (alu_sub) begin
         alu_a = chunk_ff;
         alu_b = CHUNK_W'(sub_ff);
      end else begin
         alu_a = CHUNK_W'(run_ff);
         alu_b = CHUNK_W'(rd_entry.elen);
      end
   end

   // rank of the stored entry under the scan
   always_comb begin
      theirs_base = base_order(rd_entry.etype);
      if (theirs_base == ORD_DEST1) begin
         theirs = seen_ff ? ORD_DEST2 : ORD_DEST1;
      end else begin
         theirs = theirs_base;
      end
   end

   assign mine_known = (mine_ff != ORD_UNKNOWN);
   assign type_hit   = (rd_entry.etype == type_ff);
   assign req_accept = req_tvalid && req_tready;
   assign bad_len    = (req_tdata[19:8] == '0) || (req_tdata[10:8] != 3'd0)
                       || (req_tdata[19:8] > LEN_W'(LEN_MAX));

   // saturate lengths for the result beat
   assign total_sat  = (CHUNK_W'(run_ff) > CHUNK_W'(LEN15_MAX))
                       ? TOTAL_W'(LEN15_MAX) : TOTAL_W'(run_ff);
   assign unfrag_sat = (CHUNK_W'(unfrag_ff) > CHUNK_W'(LEN15_MAX))
                       ? TOTAL_W'(LEN15_MAX) : TOTAL_W'(unfrag_ff);
   assign frag_val   = (nofrag_ff || alu_carry) ? '0 : alu_res;

   // sequencer: next state, store writes and result load
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      func_in      = func_ff;
      type_in      = type_ff;
      len_in       = len_ff;
      occ_in       = occ_ff;
      chunk_in     = chunk_ff;
      status_in    = status_ff;
      ftype_in     = ftype_ff;
      flen_in      = flen_ff;
      mine_in      = mine_ff;
      seen_in      = seen_ff;
      run_in       = run_ff;
      unfrag_in    = unfrag_ff;
      sub_in       = sub_ff;
      nofrag_in    = nofrag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_up[AW-1:0];
      wr_entry     = rd_entry;
      req_tready   = (state_ff == SEQ_IDLE);

      case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               func_in   = req_tuser;
               type_in   = req_tdata[7:0];
               len_in    = req_tdata[19:8];
               occ_in    = req_tdata[22:20];
               chunk_in  = req_tdata[39:23];
               status_in = STAT_OK;
               pos_in    = '0;
               ftype_in  = '0;
               flen_in   = '0;
               mine_in   = base_order(req_tdata[7:0]);
               seen_in   = 1'b0;
               run_in    = RUN_W'(HDR_BYTES);
               unfrag_in = RUN_W'(HDR_BYTES);
               sub_in    = RUN_W'(HDR_BYTES);
               nofrag_in = 1'b1;
               idx_in    = '0;
               case (req_tuser)
                  FN_INSERT: begin
                     if (bad_len) begin
                        status_in = STAT_BAD_LEN;
                        state_in  = SEQ_LEN;
                     end else begin
                        state_in = SEQ_SCAN;
                     end
                  end
                  FN_FIND: begin
                     state_in = SEQ_SCAN;
                  end
                  FN_REMOVE_FIRST, FN_REMOVE_TYPE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = SEQ_LEN;
                     end else begin
                        state_in = SEQ_SCAN;
                     end
                  end
                  default: begin
                     state_in = SEQ_LEN;
                  end
               endcase
            end
         end

         SEQ_SCAN: begin
            idx_in = idx_up;
            case (func_ff)
               FN_INSERT: begin
                  if ((idx_ff == count_ff) || (mine_known && (theirs > mine_ff))) begin
                     // insertion point found: check room, then open a slot
                     if (count_ff >= MAX_CNT) begin
                        status_in = STAT_FULL;
                        idx_in    = '0;
                        state_in  = SEQ_LEN;
                     end else begin
                        pos_in = idx_ff;
                        if (idx_ff == count_ff) begin
                           state_in = SEQ_PUT;
                        end else begin
                           idx_in   = cnt_dn;
                           state_in = SEQ_SHIFT_UP;
                        end
                     end
                  end else begin
                     if (theirs_base == ORD_DEST1) begin
                        seen_in = 1'b1;
                     end
                     if (mine_known && (theirs == mine_ff)) begin
                        if (mine_ff == ORD_DEST1) begin
                           mine_in = ORD_DEST2;
                        end else begin
                           status_in = STAT_DUP;
                           idx_in    = '0;
                           state_in  = SEQ_LEN;
                        end
                     end
                  end
               end
               FN_FIND: begin
                  if (idx_ff == count_ff) begin
                     status_in = STAT_NOT_FOUND;
                     idx_in    = '0;
                     state_in  = SEQ_LEN;
                  end else if (type_hit) begin
                     if (occ_ff == '0) begin
                        pos_in   = idx_ff;
                        ftype_in = rd_entry.etype;
                        flen_in  = rd_entry.elen;
                        idx_in   = '0;
                        state_in = SEQ_LEN;
                     end else begin
                        occ_in = occ_ff - OCC_W'(1);
                     end
                  end
               end
               default: begin
                  // remove first matches the head entry
                  if (idx_ff == count_ff) begin
                     status_in = STAT_NOT_FOUND;
                     idx_in    = '0;
                     state_in  = SEQ_LEN;
                  end else if (type_hit || (func_ff == FN_REMOVE_FIRST)) begin
                     pos_in   = (func_ff == FN_REMOVE_FIRST) ? '0 : idx_ff;
                     ftype_in = rd_entry.etype;
                     flen_in  = rd_entry.elen;
                     if (idx_up == count_ff) begin
                        count_in = cnt_dn;
                        idx_in   = '0;
                        state_in = SEQ_LEN;
                     end else begin
                        state_in = SEQ_SHIFT_DOWN;
                     end
                  end
               end
            endcase
         end

         SEQ_SHIFT_UP: begin
            // move entry one place toward the tail
            wr_en   = 1'b1;
            wr_addr = idx_up[AW-1:0];
            if (idx_ff == pos_ff) begin
               state_in = SEQ_PUT;
            end else begin
               idx_in = idx_dn;
            end
         end

         SEQ_SHIFT_DOWN: begin
            // move entry one place toward the head
            wr_en   = 1'b1;
            wr_addr = idx_dn[AW-1:0];
            if (idx_ff == cnt_dn) begin
               count_in = cnt_dn;
               state_in = SEQ_LEN_START;
            end else begin
               idx_in = idx_up;
            end
         end

         SEQ_PUT: begin
            wr_en          = 1'b1;
            wr_addr        = pos_ff[AW-1:0];
            wr_entry.etype = type_ff;
            wr_entry.elen  = len_ff;
            count_in       = count_ff + CW'(1);
            state_in       = SEQ_LEN_START;
         end

         SEQ_LEN_START: begin
            idx_in   = '0;
            state_in = SEQ_LEN;
         end

         SEQ_LEN: begin
            // accumulate lengths over the chain
            if (idx_ff == count_ff) begin
               state_in = SEQ_FRAG;
            end else begin
               idx_in = idx_up;
               run_in = RUN_W'(alu_res);
               if ((rd_entry.etype == T_ROUTING) || (rd_entry.etype == T_HOP)) begin
                  unfrag_in = RUN_W'(alu_res);
               end
               if ((rd_entry.etype == T_FRAGMENT) && nofrag_ff) begin
                  sub_in    = RUN_W'(alu_res);
                  nofrag_in = 1'b0;
               end
            end
         end

         SEQ_FRAG: begin
            // load the result beat once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {4'd0, nofrag_ff, frag_val, unfrag_sat, total_sat,
                               COUNT_W'(count_ff), flen_ff, ftype_ff, POS_W'(pos_ff)};
               state_in     = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      func_ff     <= func_in;
      type_ff     <= type_in;
      len_ff      <= len_in;
      occ_ff      <= occ_in;
      chunk_ff    <= chunk_in;
      status_ff   <= status_in;
      ftype_ff    <= ftype_in;
      flen_ff     <= flen_in;
      mine_ff     <= mine_in;
      seen_ff     <= seen_in;
      run_ff      <= run_in;
      unfrag_ff   <= unfrag_in;
      sub_ff      <= sub_in;
      nofrag_ff   <= nofrag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `IEHC_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_CNT)
   `IEHC_ASSERT_NXT(a_busy_after_accept, clock, reset, req_accept, !req_tready)
   `IEHC_ASSERT_IMP(a_count_moves_in_edit, clock, reset, !$stable(count_ff),
                    (state_ff == SEQ_LEN) || (state_ff == SEQ_LEN_START))
   `IEHC_ASSERT_IMP(a_nofrag_zero_len, clock, reset, rsp_tvalid && rsp_tdata[75],
                    rsp_tdata[74:58] == '0)

endmodule

FILE: rtl/iehc_store.sv
// ----------------------------------------------------------------------------
// IPv6 extension header chain table - entry store
// Single write port, single registered read port for (type, length) entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iehc_store
   import iehc_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_entry,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_entry
);

   entry_type mem_ff [DEPTH];
   entry_type rd_entry_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   // register read data
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

FILE: rtl/iehc_alu.sv
// ----------------------------------------------------------------------------
// IPv6 extension header chain table - shared adder
// Add or subtract unit used for running length sums and fragment length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iehc_alu
   import iehc_pkg::*;
(
   input  logic [CHUNK_W-1:0] op_a,
   input  logic [CHUNK_W-1:0] op_b,
   input  logic               op_sub,
   output logic [CHUNK_W-1:0] result,
   output logic               carry_out
);

   logic [CHUNK_W:0] wide;

   // carry_out is the borrow on subtract
   always_comb begin
      if (op_sub) begin
         wide = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         wide = {1'b0, op_a} + {1'b0, op_b};
      end
   end

   assign result    = wide[CHUNK_W-1:0];
   assign carry_out = wide[CHUNK_W];

endmodule
